// ----- rtl/u2u8_pkg.sv -----
// Package for the UTF-16 to UTF-8 transcoder: job type, status codes, byte builder.
package u2u8_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LONE_LOW  = 2'd1;
  localparam logic [1:0] ST_UNPAIRED  = 2'd2;
  localparam logic [1:0] ST_PARTIAL   = 2'd3;

  // byte-count codes (number of bytes minus one)
  localparam logic [1:0] NB_ONE   = 2'd0;
  localparam logic [1:0] NB_TWO   = 2'd1;
  localparam logic [1:0] NB_THREE = 2'd2;
  localparam logic [1:0] NB_FOUR  = 2'd3;

  // one classified item waiting to be serialized
  typedef struct packed {
    logic [20:0] cp;        // code point, zero for error and NUL items
    logic [1:0]  nb;        // byte count minus one
    logic        str_end;   // last byte closes the string
    logic [1:0]  status;
  } job_t;

  // UTF-8 byte number idx of a code point encoded in nb+1 bytes
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] nb,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (nb)
      NB_ONE:   b = {1'b0, cp[6:0]};
      NB_TWO: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      NB_THREE: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/utf16_to_utf8_transcoder_unit.sv -----
// UTF-16 to UTF-8 transcoder, top level: front end, job queue and byte serializer.
// The first byte of a unit passes through the job queue, the serializer's job register
// and the output register.
// Throughput: one output byte per cycle while byte_ready is high and jobs are queued; a unit yields
// 1 to 4 bytes (zero for a held high surrogate), paced by the byte-wide output port.
// A four-entry job queue lets input intake run ahead of the output by up to four queued jobs.
// Reset: synchronous, clears surrogate and error state, empties queue and output.
module utf16_to_utf8_transcoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        unit_valid,
  output logic        unit_ready,
  input  logic [15:0] code_unit,
  input  logic        is_last,
  output logic        byte_valid,
  input  logic        byte_ready,
  output logic [7:0]  out_byte,
  output logic        run_end,
  output logic        string_end,
  output logic [1:0]  status
);
  import u2u8_pkg::*;

  logic accept, push, pop, q_full, q_nonempty;
  job_t push_job, q_head;

  assign unit_ready = !q_full;
  assign accept     = unit_valid && unit_ready;

  u2u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .code_unit (code_unit),
    .is_last   (is_last),
    .push      (push),
    .job       (push_job)
  );

  u2u8_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  u2u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (pop),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end),
    .status     (status)
  );

  // an error item is a single zero byte that closes the string
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && status != ST_OK) |-> (out_byte == 8'h00 && run_end && string_end))
    else $error("error item with bad shape");

  // string end only on the last byte of a unit
  a_str_run: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && string_end) |-> run_end)
    else $error("string_end without run_end");

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue overflow");

  // in the cycle after reset is sampled, the queue is empty and no output is pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!byte_valid && !q_nonempty))
    else $error("state not cleared by reset");

endmodule

// ----- rtl/u2u8_front.sv -----
// Front end: surrogate pairing, error tracking and classification of each code unit.
module u2u8_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [15:0]          code_unit,
  input  logic                 is_last,
  output logic                 push,
  output u2u8_pkg::job_t       job
);
  import u2u8_pkg::*;

  logic [9:0] pending_high_bits, pending_high_bits_next;
  logic       pending_valid, pending_valid_next;
  logic       string_failed, string_failed_next;

  logic        is_zero, ends, is_low, is_high, emit;
  logic [20:0] cp;

  assign is_zero = (code_unit == 16'h0000);
  assign ends    = is_last || is_zero;
  assign is_low  = (code_unit[15:10] == 6'b110111);
  assign is_high = (code_unit[15:10] == 6'b110110);

  // classify the unit and work out the next state
  always_comb begin
    pending_high_bits_next = pending_high_bits;
    pending_valid_next     = pending_valid;
    string_failed_next     = string_failed;
    emit                   = 1'b0;
    cp                     = 21'd0;
    job                    = '0;
    job.nb                 = NB_ONE;
    job.str_end            = 1'b1;
    job.status             = ST_OK;

    if (string_failed) begin
      string_failed_next = !ends;
    end else if (is_zero) begin
      emit                   = 1'b1;
      job.status             = pending_valid ? ST_PARTIAL : ST_OK;
      pending_valid_next     = 1'b0;
      pending_high_bits_next = 10'd0;
    end else if (is_low && !pending_valid) begin
      emit               = 1'b1;
      job.status         = ST_LONE_LOW;
      string_failed_next = !ends;
    end else if (!is_low && pending_valid) begin
      emit                   = 1'b1;
      job.status             = ST_UNPAIRED;
      string_failed_next     = !ends;
      pending_valid_next     = 1'b0;
      pending_high_bits_next = 10'd0;
    end else if (is_high) begin
      if (is_last) begin
        emit       = 1'b1;
        job.status = ST_PARTIAL;
      end else begin
        pending_valid_next     = 1'b1;
        pending_high_bits_next = code_unit[9:0];
      end
    end else begin
      // plain BMP unit or completed surrogate pair
      emit = 1'b1;
      if (is_low) begin
        cp                     = {1'b0, pending_high_bits, code_unit[9:0]} + 21'h10000;
        pending_valid_next     = 1'b0;
        pending_high_bits_next = 10'd0;
      end else begin
        cp = {5'd0, code_unit};
      end
      job.cp      = cp;
      job.str_end = is_last;
      if (cp < 21'h80)         job.nb = NB_ONE;
      else if (cp < 21'h800)   job.nb = NB_TWO;
      else if (cp < 21'h10000) job.nb = NB_THREE;
      else                     job.nb = NB_FOUR;
    end
  end

  assign push = accept && emit;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high_bits <= 10'd0;
      pending_valid     <= 1'b0;
      string_failed     <= 1'b0;
    end else if (accept) begin
      pending_high_bits <= pending_high_bits_next;
      pending_valid     <= pending_valid_next;
      string_failed     <= string_failed_next;
    end
  end

endmodule

// ----- rtl/u2u8_queue.sv -----
// Short job queue between the front end and the byte serializer.
module u2u8_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u2u8_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           nonempty,
  output u2u8_pkg::job_t head
);
  import u2u8_pkg::*;

  job_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full     = (count == QCntW'(QDepth));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/u2u8_back.sv -----
// Back end: turns queued jobs into UTF-8 bytes, one per cycle while the output is not stalled, into an output register.
module u2u8_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_nonempty,
  input  u2u8_pkg::job_t q_head,
  output logic           q_pop,
  output logic           byte_valid,
  input  logic           byte_ready,
  output logic [7:0]     out_byte,
  output logic           run_end,
  output logic           string_end,
  output logic [1:0]     status
);
  import u2u8_pkg::*;

  job_t       job;
  logic       active;
  logic [1:0] idx;
  logic       emit, last_byte;

  assign emit      = active && (!byte_valid || byte_ready);
  assign last_byte = (idx == job.nb);
  assign q_pop     = q_nonempty && (!active || (emit && last_byte));

  // serializer control
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      byte_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (emit) byte_valid <= 1'b1;
      else if (byte_ready) byte_valid <= 1'b0;
      if (q_pop) begin
        active <= 1'b1;
        idx    <= 2'd0;
      end else if (emit) begin
        idx <= idx + 2'd1;
        if (last_byte) active <= 1'b0;
      end
    end
  end

  // job and output payload
  always_ff @(posedge clk) begin
    if (q_pop) job <= q_head;
    if (emit) begin
      out_byte   <= utf8_byte(job.cp, job.nb, idx);
      run_end    <= last_byte;
      string_end <= last_byte && job.str_end;
      status     <= job.status;
    end
  end

endmodule

// ----- bench/tb_utf16_to_utf8_transcoder_unit.sv -----
// Self-checking testbench for the UTF-16 to UTF-8 transcoder unit.
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder_unit;
  import u2u8_pkg::*;

  localparam logic [15:0] HI_FIRST = 16'hD800;
  localparam logic [15:0] LO_FIRST = 16'hDC00;
  localparam logic [15:0] SURR_END = 16'hE000;
  localparam int PHASE_UNITS = 55;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 20;

  // one UTF-16 code unit with its end-of-string flag
  typedef struct packed {
    logic [15:0] cu;
    logic        lst;
  } unit_t;

  // one UTF-8 byte as the block should emit it
  typedef struct packed {
    logic [7:0] data;
    logic       run;
    logic       str;
    logic [1:0] st;
  } utf8_byte_t;

  // Tracks surrogate/error state and the queue of UTF-8 bytes still owed.
  class utf8_byte_tracker;
    logic [9:0] hi_bits;
    logic       hi_held;
    logic       str_dropped;
    utf8_byte_t due_bytes[$];
    int         fails;
    int         n_units;
    int         n_bytes;
    int         n_err[4];

    function new();
      hi_bits     = '0;
      hi_held     = 1'b0;
      str_dropped = 1'b0;
      fails       = 0;
      n_units     = 0;
      n_bytes     = 0;
      foreach (n_err[i]) n_err[i] = 0;
    endfunction

    function void owe(logic [7:0] d, logic r, logic s, logic [1:0] st);
      utf8_byte_t b;
      b.data = d;
      b.run  = r;
      b.str  = s;
      b.st   = st;
      due_bytes.push_back(b);
    endfunction

    // error result: single zero byte closing the string
    function void flag_error(logic [1:0] st, logic ends);
      hi_held     = 1'b0;
      hi_bits     = '0;
      str_dropped = !ends;
      owe(8'h00, 1'b1, 1'b1, st);
    endfunction

    // note an accepted code unit and work out the bytes it causes
    function void accept_unit(logic [15:0] cu, logic lst);
      logic        ends;
      logic [20:0] cp;
      logic [20:0] sh;
      logic [7:0]  lead;
      int          nb;
      ends = lst || (cu == 16'h0000);
      if (str_dropped) begin
        if (ends) str_dropped = 1'b0;
        return;
      end
      n_units++;
      if (cu == 16'h0000) begin
        if (hi_held) flag_error(ST_PARTIAL, 1'b1);
        else owe(8'h00, 1'b1, 1'b1, ST_OK);
        return;
      end
      if (cu >= LO_FIRST && cu < SURR_END) begin
        if (!hi_held) begin
          flag_error(ST_LONE_LOW, ends);
          return;
        end
        cp      = 21'h10000 + {hi_bits, cu[9:0]};
        hi_held = 1'b0;
        hi_bits = '0;
      end else begin
        if (hi_held) begin
          flag_error(ST_UNPAIRED, ends);
          return;
        end
        if (cu >= HI_FIRST && cu < LO_FIRST) begin
          if (lst) begin
            flag_error(ST_PARTIAL, 1'b1);
            return;
          end
          hi_bits = cu[9:0];
          hi_held = 1'b1;
          return;
        end
        cp = {5'b0, cu};
      end
      // lead byte, then continuation bytes from the top down
      if (cp < 21'h80) begin
        nb   = 1;
        lead = {1'b0, cp[6:0]};
      end else if (cp < 21'h800) begin
        nb   = 2;
        lead = 8'hC0 | cp[10:6];
      end else if (cp < 21'h10000) begin
        nb   = 3;
        lead = 8'hE0 | cp[15:12];
      end else begin
        nb   = 4;
        lead = 8'hF0 | cp[20:18];
      end
      owe(lead, nb == 1, (nb == 1) && lst, ST_OK);
      for (int i = nb - 2; i >= 0; i--) begin
        sh = cp >> (6 * i);
        owe({2'b10, sh[5:0]}, i == 0, (i == 0) && lst, ST_OK);
      end
    endfunction

    function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        fails++;
      end
    endfunction

    // compare one accepted output byte with the oldest one owed
    function void check_byte(logic [7:0] d, logic r, logic s, logic [1:0] st);
      utf8_byte_t e;
      if (due_bytes.size() == 0) begin
        $error("byte 0x%0h arrived with nothing outstanding", d);
        fails++;
        return;
      end
      e = due_bytes.pop_front();
      n_bytes++;
      if (e.st != ST_OK) n_err[e.st]++;
      cmp_field("out_byte", e.data, d);
      cmp_field("run_end", {7'b0, e.run}, {7'b0, r});
      cmp_field("string_end", {7'b0, e.str}, {7'b0, s});
      cmp_field("status", {6'b0, e.st}, {6'b0, st});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        unit_valid = 1'b0;
  logic        unit_ready;
  logic [15:0] code_unit = '0;
  logic        is_last = 1'b0;
  logic        byte_valid;
  logic        byte_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        run_end;
  logic        string_end;
  logic [1:0]  status;

  utf8_byte_tracker book;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req = 0;

  utf16_to_utf8_transcoder_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .code_unit  (code_unit),
    .is_last    (is_last),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end),
    .status     (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // offer one code unit and return at the edge that accepts it
  task automatic send_unit(input logic [15:0] cu, input logic lst);
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      unit_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    unit_valid <= 1'b1;
    code_unit  <= cu;
    is_last    <= lst;
    @(posedge clk);
    while (!unit_ready) @(posedge clk);
    book.accept_unit(cu, lst);
  endtask

  // stop offering and wait for every owed byte
  task automatic drain();
    unit_valid <= 1'b0;
    while (book.due_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_scalar();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(16'h7F, 16'h01));
      1:       return 16'($urandom_range(16'h7FF, 16'h80));
      2:       return 16'($urandom_range(16'hD7FF, 16'h800));
      default: return 16'($urandom_range(16'hFFFF, 16'hE000));
    endcase
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'($urandom_range(16'hDBFF, 16'hD800));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'($urandom_range(16'hDFFF, 16'hDC00));
  endfunction

  // mostly well-formed strings, some broken pairs and raw noise
  task automatic send_rand_string();
    unit_t s[$];
    unit_t u;
    int    n;
    n = $urandom_range(6, 1);
    repeat (n) begin
      u.lst = 1'b0;
      case ($urandom_range(9))
        6, 7: begin
          u.cu = rand_high();
          s.push_back(u);
          u.cu = rand_low();
        end
        8: begin
          case ($urandom_range(2))
            0: u.cu = rand_low();
            1: begin
              u.cu = rand_high();
              s.push_back(u);
              u.cu = $urandom_range(1) ? rand_high() : pick_scalar();
            end
            default: u.cu = 16'h0000;
          endcase
        end
        9: begin
          u.cu  = 16'($urandom_range(16'hFFFF));
          u.lst = 1'($urandom_range(1));
        end
        default: u.cu = pick_scalar();
      endcase
      s.push_back(u);
    end
    // terminator: NUL, dangling high surrogate, or flag on the last unit
    case ($urandom_range(9))
      0: begin
        u.cu  = 16'h0000;
        u.lst = 1'($urandom_range(1));
        s.push_back(u);
      end
      1: begin
        u.cu  = rand_high();
        u.lst = 1'b1;
        s.push_back(u);
      end
      default: begin
        u     = s.pop_back();
        u.lst = 1'b1;
        s.push_back(u);
      end
    endcase
    foreach (s[k]) send_unit(s[k].cu, s[k].lst);
  endtask

  task automatic run_phase(input int snd, input int rcv, input logic hold);
    int start;
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    start = book.n_units;
    if (hold) hold_req++;
    while (book.n_units - start < PHASE_UNITS) send_rand_string();
    drain();
  endtask

  // output side: check accepted bytes, random stalls, long hold-off on request
  initial begin : byte_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && byte_valid && byte_ready)
        book.check_byte(out_byte, run_end, string_end, status);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        byte_ready <= 1'b0;
        hold_left--;
      end else begin
        byte_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    book = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: encoding boundaries, pairs, NUL and every error case
    snd_idle_pct = 15;
    rcv_idle_pct = 83;
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0000, 1'b1);
    // lone low surrogate, rest of string dropped
    send_unit(16'hDC05, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b1);
    // high followed by a plain unit, then by another high
    send_unit(16'hD801, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'hD802, 1'b0);
    send_unit(16'hD803, 1'b0);
    send_unit(16'h0030, 1'b1);
    // high surrogate at end: flagged last, then cut by NUL
    send_unit(16'hDABC, 1'b1);
    send_unit(16'hD900, 1'b0);
    send_unit(16'h0000, 1'b0);
    drain();

    run_phase(15, 83, 1'b0);
    run_phase(83, 15, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Applied %0d live code units across slow-sender, slow-receiver and back-pressure",
             book.n_units);
    $display("phases; %0d bytes checked, errors: lone low %0d, unpaired %0d, partial %0d",
             book.n_bytes, book.n_err[ST_LONE_LOW], book.n_err[ST_UNPAIRED],
             book.n_err[ST_PARTIAL]);
    if (book.fails == 0)
      $display("utf16_to_utf8_transcoder_unit verification clean");
    else
      $display("utf16_to_utf8_transcoder_unit verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("utf16_to_utf8_transcoder_unit verification failed");
    $finish;
  end

endmodule
